// ----- rtl/core/uih_pkg.sv -----
// Shared types and constants for the update-interval histogram.
// Holds field widths, request/status codes, the queue entry and state enums.
// No dependencies.
package uih_pkg;

	localparam int ADDR_W   = 23;
	localparam int BIN_W    = 15;
	localparam int REGION_W = 20;
	localparam int TS_W     = 32;
	localparam int COUNT_W  = 32;
	localparam int TOTAL_W  = 40;
	localparam int SUM_W    = 48;
	localparam int CFG_W    = 11;
	localparam int STATUS_W = 3;
	localparam int IVAL_W   = 15;
	localparam int PCNT_W   = 10;

	localparam logic [CFG_W-1:0] PPB_RESET = 11'd256;
	localparam logic [CFG_W-1:0] PPB_MAX   = 11'd1024;
	localparam logic [CFG_W-1:0] PPB_MIN   = 11'd1;
	localparam logic [TS_W-1:0]  TS_RESET  = 32'd1;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] ST_RECORDED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FIRST    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READ     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_CLEAR,
		OP_IGNORE
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [REGION_W-1:0] region;
		logic [BIN_W-1:0]    bin;
		logic [TS_W-1:0]     ts;
	} queue_entry_t;

	typedef enum logic [1:0] {
		BK_SWEEP,
		BK_IDLE,
		BK_LOOKUP,
		BK_COUNT
	} back_state_t;

endpackage

// ----- rtl/core/uih_front.sv -----
// Front end: accepts requests, keeps the page counter and block timestamp,
// finds the region by reciprocal multiply and classifies each item.
// Depends on uih_pkg.
module uih_front #(
	parameter int REGION_PAGES = 100,
	parameter int REGION_COUNT = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [uih_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       req_type,
	input  logic [uih_pkg::ADDR_W-1:0]       page_address,
	input  logic [uih_pkg::BIN_W-1:0]        bin_index,
	input  logic                             clearing,
	output logic                             push_valid,
	input  logic                             push_ready,
	output uih_pkg::queue_entry_t            push_entry
);

	// n / d == (n * m) >> s for every 23-bit n, with m = ceil(2^s / d)
	localparam int          SHIFT   = uih_pkg::ADDR_W + $clog2(REGION_PAGES);
	localparam logic [63:0] RECIP   = ((64'd1 << SHIFT) + 64'(REGION_PAGES) - 64'd1)
		/ 64'(REGION_PAGES);
	localparam int          M_W     = uih_pkg::ADDR_W + 1;
	localparam int          PROD_W  = uih_pkg::ADDR_W + M_W;
	localparam logic [M_W-1:0] RECIP_M = RECIP[M_W-1:0];

	logic [uih_pkg::CFG_W-1:0]  ppb_q;
	logic [uih_pkg::PCNT_W-1:0] pcnt_q;
	logic [uih_pkg::TS_W-1:0]   ts_q;

	logic                        valid_s1;
	logic [1:0]                  req_s1;
	logic [uih_pkg::ADDR_W-1:0]  addr_s1;
	logic [uih_pkg::BIN_W-1:0]   bin_s1;

	logic                        valid_s2;
	logic [1:0]                  req_s2;
	logic [PROD_W-1:0]           prod_s2;
	logic [uih_pkg::BIN_W-1:0]   bin_s2;
	logic [uih_pkg::TS_W-1:0]    ts_s2;

	logic                        advance_s2;
	logic [uih_pkg::CFG_W-1:0]   limit;
	logic [uih_pkg::CFG_W-1:0]   cnt_inc;
	logic [uih_pkg::PCNT_W-1:0]  pcnt_next;
	logic [uih_pkg::TS_W-1:0]    ts_next;
	logic [PROD_W-1:0]           quot_full;
	logic [uih_pkg::ADDR_W-1:0]  quot;
	logic                        in_range;

	assign advance_s2 = !valid_s2 || push_ready;
	assign in_ready   = (!valid_s1 || advance_s2) && !clearing;

	always_comb begin
		if (ppb_q == '0) begin
			limit = uih_pkg::PPB_MIN;
		end else if (ppb_q > uih_pkg::PPB_MAX) begin
			limit = uih_pkg::PPB_MAX;
		end else begin
			limit = ppb_q;
		end
		cnt_inc = {1'b0, pcnt_q} + 11'd1;
		if (cnt_inc >= limit) begin
			pcnt_next = '0;
			ts_next   = ts_q + 32'd1;
		end else begin
			pcnt_next = cnt_inc[uih_pkg::PCNT_W-1:0];
			ts_next   = ts_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppb_q    <= uih_pkg::PPB_RESET;
			pcnt_q   <= '0;
			ts_q     <= uih_pkg::TS_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				ppb_q <= cfg_wdata;
			end
			// drain stage 1 even while input is held off by a clearing pass
			if (!valid_s1 || advance_s2) begin
				valid_s1 <= in_valid && in_ready;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
			// writes advance the counter in issue order, even ignored ones
			if (valid_s1 && advance_s2 && req_s1 == uih_pkg::REQ_WRITE) begin
				pcnt_q <= pcnt_next;
				ts_q   <= ts_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_type;
			addr_s1 <= page_address;
			bin_s1  <= bin_index;
		end
		if (advance_s2 && valid_s1) begin
			req_s2  <= req_s1;
			prod_s2 <= PROD_W'(addr_s1) * PROD_W'(RECIP_M);
			bin_s2  <= bin_s1;
			ts_s2   <= (req_s1 == uih_pkg::REQ_WRITE) ? ts_next : ts_q;
		end
	end

	always_comb begin
		quot_full = prod_s2 >> SHIFT;
		quot      = quot_full[uih_pkg::ADDR_W-1:0];
		in_range  = 32'(quot) < 32'(REGION_COUNT);
		push_entry.region = quot[uih_pkg::REGION_W-1:0];
		push_entry.bin    = bin_s2;
		push_entry.ts     = ts_s2;
		case (req_s2)
			uih_pkg::REQ_WRITE: begin
				push_entry.op = in_range ? uih_pkg::OP_WRITE : uih_pkg::OP_IGNORE;
			end
			uih_pkg::REQ_READ: begin
				push_entry.op = uih_pkg::OP_READ;
			end
			uih_pkg::REQ_CLEAR: begin
				push_entry.op = uih_pkg::OP_CLEAR;
			end
			default: begin
				push_entry.op = uih_pkg::OP_IGNORE;
			end
		endcase
	end

	assign push_valid = valid_s2;

endmodule

// ----- rtl/core/uih_queue.sv -----
// Two-entry queue of classified items between the front and back ends.
// Depends on uih_pkg for the entry type.
module uih_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  uih_pkg::queue_entry_t push_entry,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output uih_pkg::queue_entry_t pop_entry
);

	localparam int DEPTH = 2;

	uih_pkg::queue_entry_t entries_q [DEPTH];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = count_q != 2'(DEPTH);
	assign pop_valid  = count_q != 2'd0;
	assign pop_entry  = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- rtl/core/uih_back.sv -----
// Back end: owns the region stamp memory, the histogram memory and totals,
// runs the clearing sweep and holds the result register.
// Depends on uih_pkg.
module uih_back #(
	parameter int HISTOGRAM_BINS = 32768,
	parameter int REGION_COUNT   = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	input  uih_pkg::queue_entry_t            pop_entry,
	output logic                             clearing,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [uih_pkg::STATUS_W-1:0]     status,
	output logic [uih_pkg::IVAL_W-1:0]       interval,
	output logic [uih_pkg::COUNT_W-1:0]      bin_count,
	output logic [uih_pkg::TOTAL_W-1:0]      request_total,
	output logic [uih_pkg::SUM_W-1:0]        interval_sum,
	output logic [uih_pkg::TS_W-1:0]         timestamp_now
);

	localparam int RAW     = $clog2(REGION_COUNT);
	localparam int BAW     = $clog2(HISTOGRAM_BINS);
	localparam int SWEEP_N = (REGION_COUNT > HISTOGRAM_BINS) ? REGION_COUNT : HISTOGRAM_BINS;
	localparam int SWW     = $clog2(SWEEP_N);
	localparam int STAMP_W = uih_pkg::TS_W + 1;
	localparam logic [uih_pkg::TS_W-1:0] IV_MAX    = 32'(HISTOGRAM_BINS - 1);
	localparam logic [SWW-1:0]           SWEEP_END = SWW'(SWEEP_N - 1);

	// stamp entry: accessed mark on top, last-write stamp below
	logic [STAMP_W-1:0]          stamp_mem [REGION_COUNT];
	logic [STAMP_W-1:0]          stamp_rd_q;
	logic [uih_pkg::COUNT_W-1:0] hist_mem [HISTOGRAM_BINS];
	logic [uih_pkg::COUNT_W-1:0] hist_rd_q;

	uih_pkg::back_state_t        state_q, state_d;
	uih_pkg::queue_entry_t       op_q;
	logic [SWW-1:0]              sweep_idx_q;
	logic [BAW-1:0]              iv_q;
	logic [uih_pkg::SUM_W-1:0]   sum_q;
	logic [uih_pkg::TOTAL_W-1:0] total_q;

	logic                        out_valid_q;
	logic [uih_pkg::STATUS_W-1:0] status_q;
	logic [uih_pkg::IVAL_W-1:0]  interval_q;
	logic [uih_pkg::COUNT_W-1:0] bin_count_q;
	logic [uih_pkg::TOTAL_W-1:0] total_out_q;
	logic [uih_pkg::SUM_W-1:0]   sum_out_q;
	logic [uih_pkg::TS_W-1:0]    ts_out_q;

	logic                        do_pop;
	logic                        stamp_we;
	logic [RAW-1:0]              stamp_wa;
	logic [STAMP_W-1:0]          stamp_wd;
	logic [RAW-1:0]              stamp_ra;
	logic                        hist_we;
	logic [BAW-1:0]              hist_wa;
	logic [uih_pkg::COUNT_W-1:0] hist_wd;
	logic [BAW-1:0]              hist_ra;
	logic [uih_pkg::TS_W-1:0]    diff;
	logic [BAW-1:0]              iv;
	logic                        bin_in_range;
	logic                        totals_clear;
	logic                        totals_add;
	logic                        sweep_start;
	logic                        out_load;
	logic [uih_pkg::STATUS_W-1:0] out_status;
	logic [uih_pkg::IVAL_W-1:0]  out_interval;
	logic [uih_pkg::COUNT_W-1:0] out_count;
	logic [uih_pkg::TOTAL_W-1:0] out_total;
	logic [uih_pkg::SUM_W-1:0]   out_sum;
	logic [uih_pkg::TS_W-1:0]    iv_wide;

	assign pop_ready = (state_q == uih_pkg::BK_IDLE) && (!out_valid_q || out_ready);
	assign do_pop    = pop_valid && pop_ready;
	assign clearing  = state_q == uih_pkg::BK_SWEEP;

	assign diff         = op_q.ts - stamp_rd_q[uih_pkg::TS_W-1:0];
	assign iv           = (diff > IV_MAX) ? IV_MAX[BAW-1:0] : diff[BAW-1:0];
	assign bin_in_range = 32'(op_q.bin) < 32'(HISTOGRAM_BINS);
	assign stamp_ra     = pop_entry.region[RAW-1:0];
	assign hist_ra      = (state_q == uih_pkg::BK_LOOKUP) ? iv : BAW'(pop_entry.bin);
	assign iv_wide      = 32'(iv_q);

	always_comb begin
		state_d      = state_q;
		stamp_we     = 1'b0;
		stamp_wa     = op_q.region[RAW-1:0];
		stamp_wd     = {1'b1, op_q.ts};
		hist_we      = 1'b0;
		hist_wa      = iv_q;
		hist_wd      = hist_rd_q + 32'd1;
		totals_clear = 1'b0;
		totals_add   = 1'b0;
		sweep_start  = 1'b0;
		out_load     = 1'b0;
		out_status   = uih_pkg::ST_IGNORED;
		out_interval = '0;
		out_count    = '0;
		out_total    = total_q;
		out_sum      = sum_q;
		case (state_q)
			uih_pkg::BK_SWEEP: begin
				stamp_we = 32'(sweep_idx_q) < 32'(REGION_COUNT);
				stamp_wa = sweep_idx_q[RAW-1:0];
				stamp_wd = '0;
				hist_we  = 32'(sweep_idx_q) < 32'(HISTOGRAM_BINS);
				hist_wa  = sweep_idx_q[BAW-1:0];
				hist_wd  = '0;
				if (sweep_idx_q == SWEEP_END) begin
					state_d = uih_pkg::BK_IDLE;
				end
			end
			uih_pkg::BK_IDLE: begin
				if (do_pop) begin
					case (pop_entry.op)
						uih_pkg::OP_WRITE, uih_pkg::OP_READ: begin
							state_d = uih_pkg::BK_LOOKUP;
						end
						uih_pkg::OP_CLEAR: begin
							totals_clear = 1'b1;
							sweep_start  = 1'b1;
							out_load     = 1'b1;
							out_status   = uih_pkg::ST_CLEARED;
							out_total    = '0;
							out_sum      = '0;
							state_d      = uih_pkg::BK_SWEEP;
						end
						default: begin
							out_load   = 1'b1;
							out_status = uih_pkg::ST_IGNORED;
						end
					endcase
				end
			end
			uih_pkg::BK_LOOKUP: begin
				if (op_q.op == uih_pkg::OP_READ) begin
					out_load   = 1'b1;
					out_status = uih_pkg::ST_READ;
					out_count  = bin_in_range ? hist_rd_q : '0;
					state_d    = uih_pkg::BK_IDLE;
				end else begin
					stamp_we = 1'b1;
					if (!stamp_rd_q[uih_pkg::TS_W]) begin
						out_load   = 1'b1;
						out_status = uih_pkg::ST_FIRST;
						state_d    = uih_pkg::BK_IDLE;
					end else begin
						state_d = uih_pkg::BK_COUNT;
					end
				end
			end
			uih_pkg::BK_COUNT: begin
				hist_we      = 1'b1;
				totals_add   = 1'b1;
				out_load     = 1'b1;
				out_status   = uih_pkg::ST_RECORDED;
				out_interval = iv_wide[uih_pkg::IVAL_W-1:0];
				out_total    = total_q + 40'd1;
				out_sum      = sum_q + 48'(iv_q);
				state_d      = uih_pkg::BK_IDLE;
			end
			default: begin
				state_d = uih_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uih_pkg::BK_SWEEP;
			sweep_idx_q <= '0;
			sum_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sweep_start) begin
				sweep_idx_q <= '0;
			end else if (state_q == uih_pkg::BK_SWEEP) begin
				sweep_idx_q <= sweep_idx_q + SWW'(1);
			end
			if (totals_clear) begin
				sum_q   <= '0;
				total_q <= '0;
			end else if (totals_add) begin
				sum_q   <= out_sum;
				total_q <= out_total;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			op_q <= pop_entry;
		end
		if (state_q == uih_pkg::BK_LOOKUP) begin
			iv_q <= iv;
		end
		if (out_load) begin
			status_q    <= out_status;
			interval_q  <= out_interval;
			bin_count_q <= out_count;
			total_out_q <= out_total;
			sum_out_q   <= out_sum;
			ts_out_q    <= (state_q == uih_pkg::BK_IDLE) ? pop_entry.ts : op_q.ts;
		end
	end

	always_ff @(posedge clk) begin
		if (stamp_we) begin
			stamp_mem[stamp_wa] <= stamp_wd;
		end
		stamp_rd_q <= stamp_mem[stamp_ra];
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		hist_rd_q <= hist_mem[hist_ra];
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign interval      = interval_q;
	assign bin_count     = bin_count_q;
	assign request_total = total_out_q;
	assign interval_sum  = sum_out_q;
	assign timestamp_now = ts_out_q;

endmodule

// ----- rtl/core/update_interval_histogram.sv -----
// Path: an item passes the front end's stage registers and the queue to the back end,
// whose memory sequencer sets the throughput: one item per cycle when ignored and the
// result is not stalled; reads and first accesses hold the back end through the lookup state,
// recorded intervals through the lookup and count states (stamp read, histogram read, histogram write-back).
// Reset: asynchronous, then a clearing pass over every stamp and histogram entry
// with in_ready low; a clear request starts the same pass.
module update_interval_histogram #(
	parameter int REGION_PAGES   = 100,
	parameter int HISTOGRAM_BINS = 32768,
	parameter int REGION_COUNT   = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [uih_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       req_type,
	input  logic [uih_pkg::ADDR_W-1:0]       page_address,
	input  logic [uih_pkg::BIN_W-1:0]        bin_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [uih_pkg::STATUS_W-1:0]     status,
	output logic [uih_pkg::IVAL_W-1:0]       interval,
	output logic [uih_pkg::COUNT_W-1:0]      bin_count,
	output logic [uih_pkg::TOTAL_W-1:0]      request_total,
	output logic [uih_pkg::SUM_W-1:0]        interval_sum,
	output logic [uih_pkg::TS_W-1:0]         timestamp_now
);

	logic                  push_valid;
	logic                  push_ready;
	uih_pkg::queue_entry_t push_entry;
	logic                  pop_valid;
	logic                  pop_ready;
	uih_pkg::queue_entry_t pop_entry;
	logic                  clearing;

	uih_front #(
		.REGION_PAGES (REGION_PAGES),
		.REGION_COUNT (REGION_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.page_address (page_address),
		.bin_index    (bin_index),
		.clearing     (clearing),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_entry   (push_entry)
	);

	uih_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	uih_back #(
		.HISTOGRAM_BINS (HISTOGRAM_BINS),
		.REGION_COUNT   (REGION_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_entry     (pop_entry),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.interval      (interval),
		.bin_count     (bin_count),
		.request_total (request_total),
		.interval_sum  (interval_sum),
		.timestamp_now (timestamp_now)
	);

endmodule

// ----- rtl/core/uih_checker.sv -----
// Port-level checks for the update-interval histogram, bound to the top level.
// Depends on uih_pkg and update_interval_histogram.
module uih_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [uih_pkg::STATUS_W-1:0]     status,
	input logic [uih_pkg::IVAL_W-1:0]       interval,
	input logic [uih_pkg::COUNT_W-1:0]      bin_count,
	input logic [uih_pkg::TOTAL_W-1:0]      request_total,
	input logic [uih_pkg::SUM_W-1:0]        interval_sum
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(request_total))
		else $error("result changed while stalled");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == uih_pkg::ST_CLEARED |-> request_total == '0 && interval_sum == '0)
		else $error("clear reported nonzero totals");

	a_count_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != uih_pkg::ST_READ |-> bin_count == '0)
		else $error("bin count outside a read");

	a_interval_only_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != uih_pkg::ST_RECORDED |-> interval == '0)
		else $error("interval outside a recorded write");

	// a recorded interval that is taken never reports a zero total
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && status != uih_pkg::ST_CLEARED
		|-> request_total != '0 || status != uih_pkg::ST_RECORDED)
		else $error("recorded interval with zero total");

endmodule

bind update_interval_histogram uih_checker u_uih_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.interval      (interval),
	.bin_count     (bin_count),
	.request_total (request_total),
	.interval_sum  (interval_sum)
);
